[sv/tsag_pkg.sv]
`timescale 1ns / 1ps
// tsag_pkg: shared types and constants of the texture span address generator
// no dependencies; imported by the interfaces and every module

package tsag_pkg;

  localparam int unsigned COORD_W = 13;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned TEX_W   = 8;
  localparam int unsigned REG_W   = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned QDEPTH  = 2;

  typedef enum logic [1:0] {
    MODE_CLAMP  = 2'd0,
    MODE_REPEAT = 2'd1,
    MODE_MIRROR = 2'd2,
    MODE_ZERO   = 2'd3
  } tile_mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SCALE_U_BY_X = 3'd0,
    REG_SHEAR_V_BY_X = 3'd1,
    REG_SHEAR_U_BY_Y = 3'd2,
    REG_SCALE_V_BY_Y = 3'd3,
    REG_OFFSET_U     = 3'd4,
    REG_OFFSET_V     = 3'd5,
    REG_TILE_MODE    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [REG_W-1:0] a;
    logic signed [REG_W-1:0] b;
    logic signed [REG_W-1:0] c;
    logic signed [REG_W-1:0] d;
    logic signed [REG_W-1:0] e;
    logic signed [REG_W-1:0] f;
    tile_mode_t              mode;
  } cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] u;
    logic signed [ACC_W-1:0] v;
    logic [LEN_W-1:0]        cnt;
  } span_job_t;

endpackage

[sv/span_if.sv]
`timescale 1ns / 1ps
// span_if: span request channel, valid/ready with span_x, span_y, span_len
// depends on tsag_pkg

interface span_if import tsag_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] span_x;
  logic [COORD_W-1:0] span_y;
  logic [LEN_W-1:0]   span_len;

  modport source (output valid, output span_x, output span_y, output span_len, input ready);
  modport sink   (input valid, input span_x, input span_y, input span_len, output ready);
endinterface

[sv/texel_if.sv]
`timescale 1ns / 1ps
// texel_if: texel coordinate channel, valid/ready with tex_u, tex_v, last
// depends on tsag_pkg

interface texel_if import tsag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TEX_W-1:0] tex_u;
  logic [TEX_W-1:0] tex_v;
  logic             last;

  modport source (output valid, output tex_u, output tex_v, output last, input ready);
  modport sink   (input valid, input tex_u, input tex_v, input last, output ready);
endinterface

[sv/tsag_front.sv]
`timescale 1ns / 1ps
// tsag_front: accepts span requests and computes the Q32.32 start point
// depends on tsag_pkg and span_if; feeds tsag_queue

module tsag_front import tsag_pkg::*; #(
  parameter int MAX_SPAN = 64
) (
  input  logic       clk,
  input  logic       rst,
  span_if.sink       span,
  input  cfg_t       cfg,
  output logic       push,
  output span_job_t  job,
  input  logic       full
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_ADD,
    S_PUSH
  } state_t;

  state_t                  state;
  logic [COORD_W+16-1:0]   px;
  logic [COORD_W+16-1:0]   py;
  logic [LEN_W-1:0]        cnt;
  logic [LEN_W-1:0]        cnt_next;
  logic signed [61:0]      pax;
  logic signed [61:0]      pcy;
  logic signed [61:0]      pbx;
  logic signed [61:0]      pdy;
  logic signed [ACC_W-1:0] su;
  logic signed [ACC_W-1:0] sv;
  logic signed [ACC_W-1:0] u;
  logic signed [ACC_W-1:0] v;

  assign span.ready = (state == S_IDLE);
  assign push       = (state == S_PUSH) && !full;
  assign job        = '{u: u, v: v, cnt: cnt};

  always_comb begin
    if (span.span_len > LEN_W'(MAX_SPAN)) begin
      cnt_next = LEN_W'(MAX_SPAN);
    end else begin
      cnt_next = span.span_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (span.valid) begin
            px  <= {span.span_x, 16'h8000};
            py  <= {span.span_y, 16'h8000};
            cnt <= cnt_next;
            if (cnt_next != '0) begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          pax   <= cfg.a * $signed({1'b0, px});
          pcy   <= cfg.c * $signed({1'b0, py});
          pbx   <= cfg.b * $signed({1'b0, px});
          pdy   <= cfg.d * $signed({1'b0, py});
          state <= S_SUM;
        end
        S_SUM: begin
          su    <= ACC_W'(pax) + ACC_W'(pcy);
          sv    <= ACC_W'(pbx) + ACC_W'(pdy);
          state <= S_ADD;
        end
        S_ADD: begin
          u     <= su + $signed({{16{cfg.e[REG_W-1]}}, cfg.e, 16'h0000});
          v     <= sv + $signed({{16{cfg.f[REG_W-1]}}, cfg.f, 16'h0000});
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/tsag_queue.sv]
`timescale 1ns / 1ps
// tsag_queue: short job queue between the front and back ends
// depends on tsag_pkg

module tsag_queue import tsag_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  span_job_t din,
  output logic      full,
  input  logic      pop,
  output span_job_t dout,
  output logic      empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  span_job_t     mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/tsag_lane.sv]
`timescale 1ns / 1ps
// tsag_lane: five-stage tiling of one Q32.32 coordinate against a bound
// depends on tsag_pkg; instantiated twice by tsag_back

module tsag_lane import tsag_pkg::*; #(
  parameter int BOUND = 256
) (
  input  logic                    clk,
  input  logic                    en,
  input  tile_mode_t              mode,
  input  logic signed [ACC_W-1:0] n,
  output logic [TEX_W-1:0]        res
);

  localparam int DW = $clog2(2 * BOUND + 1);
  localparam int RW = (DW > TEX_W) ? DW : TEX_W;
  localparam logic [31:0]   M_REP = 32'((64'd1 << 31) / BOUND);
  localparam logic [31:0]   M_MIR = 32'((64'd1 << 31) / (2 * BOUND));
  localparam logic [DW-1:0] D_REP = DW'(BOUND);
  localparam logic [DW-1:0] D_MIR = DW'(2 * BOUND);
  localparam logic [63:0]   HALF  = 64'd1 << 31;

  logic signed [ACC_W-1:0] n1;
  logic signed [ACC_W-1:0] t1;
  logic [30:0]             x2;
  logic                    neg2;
  logic [30:0]             x2_next;
  logic                    neg2_next;
  logic signed [31:0]      f1;
  logic [ACC_W-1:0]        at1;
  logic [62:0]             prod3;
  logic [30:0]             x3;
  logic                    neg3;
  logic [30:0]             qd4;
  logic [30:0]             x4;
  logic                    neg4;
  logic [30:0]             r0;
  logic [DW-1:0]           r5;
  logic [30:0]             x5;
  logic                    neg5;
  logic [DW-1:0]           dsel;
  logic [RW-1:0]           res_w;

  assign dsel = (mode == MODE_MIRROR) ? D_MIR : D_REP;
  assign f1   = t1[63:32];
  assign at1  = t1[63] ? 64'(-t1) : 64'(t1);
  assign r0   = x4 - qd4;

  always_comb begin
    x2_next   = '0;
    neg2_next = 1'b0;
    unique case (mode)
      MODE_CLAMP: begin
        x2_next   = n1[62:32];
        neg2_next = n1[63];
      end
      MODE_REPEAT: begin
        neg2_next = t1[63];
        x2_next   = t1[63] ? 31'(-f1) : f1[30:0];
      end
      MODE_MIRROR: begin
        x2_next   = at1[62:32];
      end
      MODE_ZERO: begin
        x2_next   = '0;
      end
      default: begin
        x2_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1    <= n;
      t1    <= n + $signed(HALF);
      x2    <= x2_next;
      neg2  <= neg2_next;
      prod3 <= 63'(x2) * 63'((mode == MODE_MIRROR) ? M_MIR : M_REP);
      x3    <= x2;
      neg3  <= neg2;
      qd4   <= 31'(prod3[61:31] * dsel);
      x4    <= x3;
      neg4  <= neg3;
      r5    <= (r0[DW:0] >= {1'b0, dsel}) ? DW'(r0[DW:0] - {1'b0, dsel}) : r0[DW-1:0];
      x5    <= x4;
      neg5  <= neg4;
    end
  end

  always_comb begin
    res_w = '0;
    unique case (mode)
      MODE_CLAMP: begin
        if (neg5) begin
          res_w = '0;
        end else if (x5 > 31'(BOUND - 1)) begin
          res_w = RW'(BOUND - 1);
        end else begin
          res_w = RW'(x5);
        end
      end
      MODE_REPEAT: begin
        if (neg5 && (r5 != '0)) begin
          res_w = RW'(D_REP - r5);
        end else begin
          res_w = RW'(r5);
        end
      end
      MODE_MIRROR: begin
        if (r5 > DW'(BOUND - 1)) begin
          res_w = RW'(DW'(2 * BOUND - 1) - r5);
        end else begin
          res_w = RW'(r5);
        end
      end
      MODE_ZERO: begin
        res_w = '0;
      end
      default: begin
        res_w = '0;
      end
    endcase
  end

  assign res = res_w[TEX_W-1:0];

endmodule

[sv/tsag_back.sv]
`timescale 1ns / 1ps
// tsag_back: steps u and v along a span and tiles them, one beat per cycle while the texel sink accepts
// depends on tsag_pkg, texel_if and tsag_lane; drains tsag_queue

module tsag_back import tsag_pkg::*; #(
  parameter int TEX_WIDTH  = 256,
  parameter int TEX_HEIGHT = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  span_job_t job,
  input  logic      empty,
  output logic      pop,
  texel_if.source   texel
);

  localparam int NST = 5;

  logic                    active;
  logic signed [ACC_W-1:0] u;
  logic signed [ACC_W-1:0] v;
  logic [LEN_W-1:0]        rem;
  logic signed [ACC_W-1:0] du;
  logic signed [ACC_W-1:0] dv;
  logic                    adv;
  logic [NST-1:0]          vld;
  logic [NST-1:0]          lst;
  logic [TEX_W-1:0]        res_u;
  logic [TEX_W-1:0]        res_v;

  assign du  = $signed({{16{cfg.a[REG_W-1]}}, cfg.a, 16'h0000});
  assign dv  = $signed({{16{cfg.b[REG_W-1]}}, cfg.b, 16'h0000});
  assign adv = !texel.valid || texel.ready;
  assign pop = !active && !empty;

  tsag_lane #(.BOUND(TEX_WIDTH)) u_lane_u (
    .clk  (clk),
    .en   (adv),
    .mode (cfg.mode),
    .n    (u),
    .res  (res_u)
  );

  tsag_lane #(.BOUND(TEX_HEIGHT)) u_lane_v (
    .clk  (clk),
    .en   (adv),
    .mode (cfg.mode),
    .n    (v),
    .res  (res_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      vld         <= '0;
      texel.valid <= 1'b0;
    end else begin
      if (pop) begin
        u      <= job.u;
        v      <= job.v;
        rem    <= job.cnt;
        active <= 1'b1;
      end else if (active && adv) begin
        u   <= u + du;
        v   <= v + dv;
        rem <= rem - 1'b1;
        if (rem == LEN_W'(1)) begin
          active <= 1'b0;
        end
      end
      if (adv) begin
        vld         <= {vld[NST-2:0], active};
        lst         <= {lst[NST-2:0], rem == LEN_W'(1)};
        texel.valid <= vld[NST-1];
        texel.last  <= lst[NST-1];
        texel.tex_u <= res_u;
        texel.tex_v <= res_v;
      end
    end
  end

endmodule

[sv/texture_span_address_generator.sv]
`timescale 1ns / 1ps
// texture_span_address_generator: affine texel addresses for pixel spans
// throughput: one beat per cycle within a span while the texel sink accepts;
//   the front end takes one request at a time, the back end one span at a time
// reset: registers return to identity matrix and clamp mode, queue and pipe empty
// depends on tsag_pkg, span_if, texel_if, tsag_front, tsag_queue, tsag_back

module texture_span_address_generator import tsag_pkg::*; #(
  parameter int TEX_WIDTH  = 256,
  parameter int TEX_HEIGHT = 256,
  parameter int MAX_SPAN   = 64
) (
  input  logic             clk,
  input  logic             rst,
  span_if.sink             span,
  texel_if.source          texel,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      push;
  logic      full;
  logic      pop;
  logic      empty;
  span_job_t job_in;
  span_job_t job_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a    <= 32'sd65536;
      cfg.b    <= '0;
      cfg.c    <= '0;
      cfg.d    <= 32'sd65536;
      cfg.e    <= '0;
      cfg.f    <= '0;
      cfg.mode <= MODE_CLAMP;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SCALE_U_BY_X: cfg.a    <= $signed(cfg_wdata);
        REG_SHEAR_V_BY_X: cfg.b    <= $signed(cfg_wdata);
        REG_SHEAR_U_BY_Y: cfg.c    <= $signed(cfg_wdata);
        REG_SCALE_V_BY_Y: cfg.d    <= $signed(cfg_wdata);
        REG_OFFSET_U:     cfg.e    <= $signed(cfg_wdata);
        REG_OFFSET_V:     cfg.f    <= $signed(cfg_wdata);
        REG_TILE_MODE:    cfg.mode <= tile_mode_t'(cfg_wdata[1:0]);
        default: begin
        end
      endcase
    end
  end

  tsag_front #(.MAX_SPAN(MAX_SPAN)) u_front (
    .clk  (clk),
    .rst  (rst),
    .span (span),
    .cfg  (cfg),
    .push (push),
    .job  (job_in),
    .full (full)
  );

  tsag_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .full  (full),
    .pop   (pop),
    .dout  (job_out),
    .empty (empty)
  );

  tsag_back #(.TEX_WIDTH(TEX_WIDTH), .TEX_HEIGHT(TEX_HEIGHT)) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .job   (job_out),
    .empty (empty),
    .pop   (pop),
    .texel (texel)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for texture_span_address_generator, span requests in,
// tiled texel beats out, checked against an in-bench affine/tiling predictor
// depends on tsag_pkg, span_if, texel_if and the generator top

module tb;
  import tsag_pkg::*;

  localparam int TEX_WIDTH    = 256;
  localparam int TEX_HEIGHT   = 256;
  localparam int MAX_SPAN     = 64;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE       = 100;
  localparam longint HALF_Q32 = 64'sd2147483648;

  typedef struct {
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
    logic             last;
  } texel_beat_t;

  class texel_scoreboard;
    longint      coef [6];
    tile_mode_t  mode;
    texel_beat_t texels_due [$];
    int          mismatches;

    function new();
      coef = '{65536, 0, 0, 65536, 0, 0};
      mode = MODE_CLAMP;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
      if (idx == REG_TILE_MODE)
        mode = tile_mode_t'(val[1:0]);
      else if (idx < REG_TILE_MODE)
        coef[idx] = longint'($signed(val));
    endfunction

    function logic [TEX_W-1:0] tile_coord(longint n, longint bound);
      longint r;
      case (mode)
        MODE_CLAMP: begin
          if (n < 0) begin
            r = 0;
          end else begin
            r = n >>> 32;
            if (r > bound - 1) r = bound - 1;
          end
        end
        MODE_REPEAT: begin
          r = ((n + HALF_Q32) >>> 32) % bound;
          if (r < 0) r = r + bound;
        end
        MODE_MIRROR: begin
          r = n + HALF_Q32;
          if (r < 0) r = -r;
          r = (r >>> 32) % (2 * bound);
          if (r > bound - 1) r = 2 * bound - 1 - r;
        end
        default: r = 0;
      endcase
      return r[TEX_W-1:0];
    endfunction

    function void note_span(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [LEN_W-1:0] len);
      longint      px, py, u, v, du, dv;
      int          count;
      texel_beat_t beat;
      px = longint'(x) * 65536 + 32768;
      py = longint'(y) * 65536 + 32768;
      count = int'(len);
      if (count > MAX_SPAN) count = MAX_SPAN;
      u  = coef[REG_SCALE_U_BY_X] * px + coef[REG_SHEAR_U_BY_Y] * py
         + coef[REG_OFFSET_U] * 65536;
      v  = coef[REG_SHEAR_V_BY_X] * px + coef[REG_SCALE_V_BY_Y] * py
         + coef[REG_OFFSET_V] * 65536;
      du = coef[REG_SCALE_U_BY_X] * 65536;
      dv = coef[REG_SHEAR_V_BY_X] * 65536;
      for (int i = 0; i < count; i++) begin
        beat.u    = tile_coord(u, TEX_WIDTH);
        beat.v    = tile_coord(v, TEX_HEIGHT);
        beat.last = (i == count - 1);
        texels_due.push_back(beat);
        u = u + du;
        v = v + dv;
      end
    endfunction

    function void check_beat(logic [TEX_W-1:0] u, logic [TEX_W-1:0] v, logic last);
      texel_beat_t want;
      if (texels_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual u %0d v %0d last %0b",
                 $time, u, v, last);
        mismatches++;
        return;
      end
      want = texels_due.pop_front();
      if (u !== want.u) begin
        $display("%0t: tex_u mismatch, expected %0d, actual %0d", $time, want.u, u);
        mismatches++;
      end
      if (v !== want.v) begin
        $display("%0t: tex_v mismatch, expected %0d, actual %0d", $time, want.v, v);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;
  logic             sink_ready = 1'b0;
  int               stall_left = 0;
  int               sink_stall;
  int               cycles = 0;
  bit               calm = 1'b0;
  texel_scoreboard  sb = new();

  span_if  span ();
  texel_if texel ();

  assign texel.ready = sink_ready;

  texture_span_address_generator #(
    .TEX_WIDTH (TEX_WIDTH),
    .TEX_HEIGHT(TEX_HEIGHT),
    .MAX_SPAN  (MAX_SPAN)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .span     (span),
    .texel    (texel),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // texel sink with random stalls after each beat
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (texel.valid && texel.ready) begin
      sb.check_beat(texel.tex_u, texel.tex_v, texel.last);
      sink_stall = calm ? 0 : $urandom_range(0, 5);
      sink_ready <= (sink_stall == 0);
      stall_left <= sink_stall;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      sink_ready <= 1'b1;
    end
  end

  task automatic send_span(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [LEN_W-1:0] len);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      span.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    span.valid    <= 1'b1;
    span.span_x   <= x;
    span.span_y   <= y;
    span.span_len <= len;
    do @(posedge clk); while (!(span.valid && span.ready));
    sb.note_span(x, y, len);
  endtask

  task automatic wait_results(input int extra);
    span.valid <= 1'b0;
    do @(posedge clk); while (sb.texels_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic load_config(input logic [REG_W-1:0] a, b, c, d, e, f,
                             input tile_mode_t mode);
    logic [REG_W-1:0] vals [7];
    vals = '{a, b, c, d, e, f, {30'b0, mode}};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(reg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [REG_W-1:0] pick_coef(input int span_bits);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 2 << span_bits) - (1 << span_bits);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 1) == 0) return COORD_W'($urandom_range(0, 8191));
    return COORD_W'($urandom_range(0, 400));
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return LEN_W'($urandom_range(1, 12));
    else if (sel < 15) return LEN_W'($urandom_range(13, 64));
    else if (sel < 17) return LEN_W'($urandom_range(65, 127));
    else if (sel < 18) return '0;
    else return LEN_W'($urandom_range(0, 127));
  endfunction

  initial begin
    span.valid    = 1'b0;
    span.span_x   = '0;
    span.span_y   = '0;
    span.span_len = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity matrix, clamp after reset
    send_span(0, 0, 1);
    send_span(8191, 8191, 64);
    send_span(255, 3, 0);
    send_span(250, 10, 127);
    send_span(3, 200, 65);
    send_span(100, 100, 12);
    wait_results(SETTLE);

    // negative slopes: clamp at zero and truncation toward zero
    load_config(32'hFFFF_0000, 0, 0, 32'hFFFF_0000, 20 << 16, 10 << 16, MODE_CLAMP);
    send_span(0, 0, 40);
    send_span(5, 3, 30);
    send_span(0, 0, 1);
    wait_results(SETTLE);

    load_config(32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000, 32'h0001_8000,
                -(3 << 16), 7 << 16, MODE_REPEAT);
    send_span(0, 0, 64);
    send_span(8000, 123, 20);
    wait_results(SETTLE);

    load_config(32'h0002_0000, 32'hFFFF_0000, 0, 32'h0000_C000,
                -(100 << 16), 0, MODE_MIRROR);
    send_span(0, 0, 64);
    send_span(300, 40, 50);
    wait_results(SETTLE);

    load_config(32'h0001_2345, 32'h0000_7000, 32'h0000_1000, 32'h0000_F000,
                5 << 16, 9 << 16, MODE_ZERO);
    send_span(77, 88, 10);
    wait_results(SETTLE);

    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, MODE_REPEAT);
    send_span(8191, 8191, 64);
    send_span(0, 0, 3);
    wait_results(SETTLE);

    load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, MODE_MIRROR);
    send_span(8191, 0, 64);
    send_span(0, 8191, 5);
    wait_results(SETTLE);

    for (int phase = 0; phase < 10; phase++) begin
      load_config(pick_coef(17), pick_coef(17), pick_coef(14), pick_coef(17),
                  pick_coef(24), pick_coef(24), tile_mode_t'($urandom_range(0, 3)));
      calm = (phase == 3);
      for (int n = 0; n < 24; n++) begin
        if (phase == 6 && n == 12) wait_results(0);
        send_span(pick_coord(), pick_coord(), pick_len());
      end
      wait_results(SETTLE);
      calm = 1'b0;
    end

    if (sb.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
